// ----- hw/rtl/twt_pkg.sv -----
// ---------------------------------------------------------------------------
// twt_pkg: shared constants and helpers for the trace window taper
// Widths, fixed-point constants of the sine polynomial and Blackman window,
// register indexes and the weight rounding helper.
// ---------------------------------------------------------------------------
`default_nettype none

package twt_pkg;

  localparam int MAX_SAMPLES      = 4096;
  localparam int WEIGHT_FRAC_BITS = 17;
  localparam int IDX_W            = $clog2(MAX_SAMPLES);
  localparam int LEN_W            = IDX_W + 1;
  localparam int CNT_W            = LEN_W + 1;
  localparam int WT_W             = WEIGHT_FRAC_BITS + 1;
  localparam int DIV_W            = 50;
  localparam int DIV_CNT_W        = $clog2(DIV_W + 1);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SAMPLES);
  localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(2);

  localparam logic [30:0] ONE30   = 31'h4000_0000;
  localparam logic [31:0] BK_A0   = 32'd450971566;
  localparam logic [31:0] BK_A2   = 32'd85899346;
  localparam logic [31:0] SIN_S1  = 32'd1686629713;
  localparam logic [31:0] SIN_S3  = 32'd693598668;
  localparam logic [31:0] SIN_S5  = 32'd85569306;
  localparam logic [31:0] SIN_S7  = 32'd5026995;
  localparam logic [31:0] SIN_S9  = 32'd172272;
  localparam logic [31:0] SIN_S11 = 32'd3864;

  localparam logic [1:0] CFG_TRACE_LENGTH = 2'd0;
  localparam logic [1:0] CFG_TAPER_LENGTH = 2'd1;
  localparam logic [1:0] CFG_WINDOW_KIND  = 2'd2;
  localparam logic [1:0] CFG_NORM_MODE    = 2'd3;

  localparam logic [1:0] KIND_COSINE   = 2'd0;
  localparam logic [1:0] KIND_BLACKMAN = 2'd1;
  localparam logic [1:0] KIND_PASS     = 2'd2;

  localparam logic [1:0] NORM_OFF  = 2'd0;
  localparam logic [1:0] NORM_SKIP = 2'd2;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // Horner coefficients after the leading S11 term, highest order first.
  function automatic logic [31:0] sin_coef(input logic [2:0] k);
    logic [31:0] c;
    case (k)
      3'd0:    c = SIN_S9;
      3'd1:    c = SIN_S7;
      3'd2:    c = SIN_S5;
      3'd3:    c = SIN_S3;
      3'd4:    c = SIN_S1;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Round a Q30 weight half up to the weight format.
  function automatic logic [WT_W-1:0] to_w(input logic [30:0] x30);
    localparam int SH = 30 - WEIGHT_FRAC_BITS;
    logic [31:0] sum;
    logic [31:0] shifted;
    sum     = {1'b0, x30} + ((32'd1 << SH) >> 1);
    shifted = sum >> SH;
    return shifted[WT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/trace_window_taper.sv -----
// ---------------------------------------------------------------------------
// trace_window_taper: cosine edge taper / Blackman window for seismic traces
// Weights each streamed sample by its trace position unless in pass-through and,
// on a normalized last sample, returns the updated norm scalar from the accumulated weights.
// ---------------------------------------------------------------------------
//  channel | direction | tdata / fields                         | tlast | tuser
//  s_*     | in        | sample[31:0], norm_in[63:32]           | -     | -
//  m_*     | out       | sample_out[31:0], norm_out[63:32]      | last  | norm_fault
//  cfg_*   | in        | cfg_index selects, cfg_data written    | -     | -
//
//  Processing time depends on the mode: pass-through, one cosine edge, both
//  edges or the Blackman window. It is set by the radix-2 divider and the
//  shared 32x32 multiplier, which runs the sine polynomial. The last sample of
//  a trace with normalization adds up to two more divisions.
//  s_tready is high only while the sequencer is idle; a waiting result in the
//  output register does not hold off the next transaction. rst is synchronous.
`default_nettype none

module trace_window_taper (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // sample [31:0], norm_in [63:32]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // sample_out [31:0], norm_out [63:32]
  output logic             m_tlast,
  output logic             m_tuser,   // norm_fault [0]
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [twt_pkg::LEN_W-1:0] cfg_data
);
  import twt_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DISP  = 5'd1;
  localparam logic [4:0] ST_DIV   = 5'd2;
  localparam logic [4:0] ST_SIN0  = 5'd3;
  localparam logic [4:0] ST_SIN1  = 5'd4;
  localparam logic [4:0] ST_SIN2  = 5'd5;
  localparam logic [4:0] ST_SIN3  = 5'd6;
  localparam logic [4:0] ST_SIN4  = 5'd7;
  localparam logic [4:0] ST_SIN5  = 5'd8;
  localparam logic [4:0] ST_SIN6  = 5'd9;
  localparam logic [4:0] ST_SQW   = 5'd10;
  localparam logic [4:0] ST_SQ2   = 5'd11;
  localparam logic [4:0] ST_BKW   = 5'd12;
  localparam logic [4:0] ST_BK2   = 5'd13;
  localparam logic [4:0] ST_SCW   = 5'd14;
  localparam logic [4:0] ST_SCL   = 5'd15;
  localparam logic [4:0] ST_ACC   = 5'd16;
  localparam logic [4:0] ST_OUT   = 5'd17;

  localparam logic [2:0] SEG_LEAD  = 3'd0;
  localparam logic [2:0] SEG_TRAIL = 3'd1;
  localparam logic [2:0] SEG_BK    = 3'd2;
  localparam logic [2:0] SEG_C1    = 3'd3;
  localparam logic [2:0] SEG_C2    = 3'd4;
  localparam logic [2:0] SEG_NORM1 = 3'd5;
  localparam logic [2:0] SEG_NORM2 = 3'd6;

  localparam logic [DIV_W-1:0] TWO48 = DIV_W'(1) << 48;

  // Configuration and trace state
  logic [LEN_W-1:0] trace_length, taper_length;
  logic [1:0]       window_kind, norm_mode;
  logic [IDX_W-1:0] sample_index;
  logic [31:0]      weight_sum;
  logic [CNT_W-1:0] weight_count;
  logic [31:0]      held_norm_seed;

  // Sequencer and per-sample registers
  logic [4:0]       state;
  logic [2:0]       seg;
  logic [2:0]       k;
  logic [LEN_W-1:0] n_r, t_r, p_r;
  logic             last_r, lead_r, trail_r;
  logic [1:0]       kind_r, norm_r;
  logic signed [31:0] y;
  logic             y_neg;
  logic [30:0]      q, q2, s30;
  logic             qneg;
  logic [31:0]      phase;
  logic signed [31:0] c_r;
  logic [WT_W-1:0]  nl, nt;
  logic [31:0]      nout_r;
  logic             fault_r;
  logic             d_neg;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // Shared divider
  logic [DIV_W-1:0]     div_rem, div_quo, div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_W:0]       div_sh, div_diff;
  logic                 div_ge;

  // Combinational helpers
  logic [LEN_W-1:0] n_eff, t_eff, p_c, n_m1;
  logic             last_c, lead_c, trail_c;
  logic [31:0]      prod30;
  logic [30:0]      sin_r;
  logic [30:0]      sq_x;
  logic [63:0]      sc_sum, sc_p;
  logic signed [31:0] sc_y;
  logic [32:0]      c_plus;
  logic signed [34:0] bk_w30;
  logic [30:0]      bk_cl;
  logic signed [DIV_W:0] d_c, d_abs;
  logic [DIV_W:0]   recip_e, sum_sh, cnt_sh;
  logic [31:0]      seed_mag;
  logic [31:0]      norm_sat;
  logic [WT_W-1:0]  acc_add_l, acc_add_t;
  logic             do_acc;
  logic [31:0]      y_mag;

  function automatic logic [31:0] cos_q(input logic [31:0] ph);
    logic [1:0]  quad;
    logic [30:0] qq;
    logic        ng;
    quad = ph[31:30];
    if (quad == 2'd0 || quad == 2'd2) begin
      qq = ONE30 - {1'b0, ph[29:0]};
    end else begin
      qq = {1'b0, ph[29:0]};
    end
    ng = (quad == 2'd1) || (quad == 2'd2);
    return {ng, qq};
  endfunction

  always_comb begin
    if (trace_length < MIN_LEN) begin
      n_eff = MIN_LEN;
    end else if (trace_length > MAX_LEN) begin
      n_eff = MAX_LEN;
    end else begin
      n_eff = trace_length;
    end
    t_eff   = (taper_length < n_eff) ? taper_length : n_eff;
    last_c  = LEN_W'(sample_index) >= (n_eff - LEN_W'(1));
    p_c     = last_c ? (n_eff - LEN_W'(1)) : LEN_W'(sample_index);
    lead_c  = p_c < t_eff;
    trail_c = ({1'b0, p_c} + {1'b0, t_eff}) >= {1'b0, n_eff};
  end

  assign n_m1   = n_r - LEN_W'(1);
  assign prod30 = prod[61:30];
  assign sin_r  = (prod30 > {1'b0, ONE30}) ? ONE30 : prod30[30:0];
  assign y_mag  = y[31] ? (32'd0 - 32'(y)) : 32'(y);

  // s*s rounded half up to Q30
  always_comb begin
    logic [63:0] t;
    t    = prod + (64'd1 << 29);
    sq_x = t[60:30];
  end

  // Sample times weight, rounded half away from zero, saturated
  always_comb begin
    sc_sum = prod + (64'd1 << (WEIGHT_FRAC_BITS - 1));
    sc_p   = sc_sum >> WEIGHT_FRAC_BITS;
    if (y_neg) begin
      sc_y = (sc_p > 64'h8000_0000) ? $signed(SAT_MIN) : $signed(32'd0 - sc_p[31:0]);
    end else begin
      sc_y = (sc_p > 64'h7FFF_FFFF) ? $signed(SAT_MAX) : $signed(sc_p[31:0]);
    end
  end

  // Blackman weight from c (register) and the product A2*(c2+1)
  always_comb begin
    c_plus = {c_r[31], c_r} + 33'(ONE30);
    bk_w30 = $signed(35'(BK_A0)) - $signed(35'(c_plus >> 1))
           + $signed(35'(ONE30 >> 1)) + $signed(35'(prod30))
           - $signed(35'(BK_A2));
    if (bk_w30 < 0) begin
      bk_cl = '0;
    end else if (bk_w30 > $signed(35'(ONE30))) begin
      bk_cl = ONE30;
    end else begin
      bk_cl = bk_w30[30:0];
    end
  end

  // Norm divisor and final saturation
  always_comb begin
    seed_mag = held_norm_seed[31] ? (32'd0 - held_norm_seed) : held_norm_seed;
    recip_e  = {1'b0, div_quo};
    sum_sh   = (DIV_W+1)'(weight_sum) << (32 - WEIGHT_FRAC_BITS);
    cnt_sh   = (DIV_W+1)'(weight_count) << 32;
    if (held_norm_seed[31]) begin
      d_c = $signed(sum_sh) - $signed(recip_e) - $signed(cnt_sh);
    end else begin
      d_c = $signed(sum_sh) + $signed(recip_e) - $signed(cnt_sh);
    end
    d_abs = (d_c < 0) ? -d_c : d_c;
    if (d_neg) begin
      norm_sat = (div_quo > DIV_W'(33'h1_0000_0000 >> 1)) ? SAT_MIN
                                                          : (32'd0 - div_quo[31:0]);
    end else begin
      norm_sat = (div_quo > DIV_W'(SAT_MAX)) ? SAT_MAX : div_quo[31:0];
    end
  end

  always_comb begin
    acc_add_l = lead_r  ? nl : '0;
    acc_add_t = trail_r ? nt : '0;
    do_acc    = (norm_r != NORM_OFF)
             && (kind_r == KIND_COSINE || kind_r == KIND_BLACKMAN)
             && !(norm_r == NORM_SKIP && y == 0);
  end

  // One restoring step per cycle
  assign div_sh   = {div_rem, div_quo[DIV_W-1]};
  assign div_ge   = div_sh >= {1'b0, div_den};
  assign div_diff = div_sh - {1'b0, div_den};

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_length   <= MIN_LEN;
      taper_length   <= '0;
      window_kind    <= KIND_PASS;
      norm_mode      <= NORM_OFF;
      sample_index   <= '0;
      weight_sum     <= '0;
      weight_count   <= '0;
      held_norm_seed <= '0;
      state          <= ST_IDLE;
      seg            <= SEG_LEAD;
      div_cnt        <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_TRACE_LENGTH: trace_length <= cfg_data;
          CFG_TAPER_LENGTH: taper_length <= cfg_data;
          CFG_WINDOW_KIND:  window_kind  <= cfg_data[1:0];
          CFG_NORM_MODE:    norm_mode    <= cfg_data[1:0];
          default: ;
        endcase
      end

      // The output register loads in ST_OUT once it is free or being drained.
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (state == ST_DIV && div_cnt != '0) begin
        div_rem <= div_ge ? div_diff[DIV_W-1:0] : div_sh[DIV_W-1:0];
        div_quo <= {div_quo[DIV_W-2:0], div_ge};
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            y       <= $signed(s_tdata[31:0]);
            n_r     <= n_eff;
            t_r     <= t_eff;
            p_r     <= p_c;
            last_r  <= last_c;
            lead_r  <= lead_c;
            trail_r <= trail_c;
            kind_r  <= window_kind;
            norm_r  <= norm_mode;
            if (sample_index == '0) begin
              held_norm_seed <= s_tdata[63:32];
              weight_sum     <= '0;
              weight_count   <= '0;
            end
            state <= ST_DISP;
          end
        end

        ST_DISP: begin
          if (kind_r == KIND_COSINE) begin
            div_rem <= '0;
            div_cnt <= DIV_CNT_W'(DIV_W);
            if (lead_r) begin
              div_quo <= DIV_W'(p_r) << 30;
              div_den <= DIV_W'(t_r);
              seg     <= SEG_LEAD;
              state   <= ST_DIV;
            end else if (trail_r) begin
              div_quo <= DIV_W'(n_m1 - p_r) << 30;
              div_den <= DIV_W'(t_r);
              seg     <= SEG_TRAIL;
              state   <= ST_DIV;
            end else begin
              state <= ST_ACC;
            end
          end else if (kind_r == KIND_BLACKMAN) begin
            lead_r  <= 1'b1;
            trail_r <= 1'b0;
            div_rem <= '0;
            div_cnt <= DIV_CNT_W'(DIV_W);
            div_quo <= DIV_W'(p_r) << 32;
            div_den <= DIV_W'(n_m1);
            seg     <= SEG_BK;
            state   <= ST_DIV;
          end else begin
            state <= ST_ACC;
          end
        end

        ST_DIV: begin
          if (div_cnt == '0) begin
            case (seg)
              SEG_LEAD, SEG_TRAIL: begin
                q     <= div_quo[30:0];
                state <= ST_SIN0;
              end
              SEG_BK: begin
                phase       <= div_quo[31:0];
                {qneg, q}   <= cos_q(div_quo[31:0]);
                seg         <= SEG_C1;
                state       <= ST_SIN0;
              end
              SEG_NORM1: begin
                if (d_c == 0) begin
                  fault_r <= 1'b1;
                  nout_r  <= SAT_MAX;
                  state   <= ST_OUT;
                end else begin
                  d_neg   <= d_c < 0;
                  div_rem <= '0;
                  div_cnt <= DIV_CNT_W'(DIV_W);
                  div_quo <= TWO48 + (d_abs[DIV_W-1:0] >> 1);
                  div_den <= d_abs[DIV_W-1:0];
                  seg     <= SEG_NORM2;
                end
              end
              SEG_NORM2: begin
                nout_r <= norm_sat;
                state  <= ST_OUT;
              end
              default: state <= ST_ACC;
            endcase
          end
        end

        ST_SIN0: begin
          if (q > ONE30) begin
            q     <= ONE30;
            mul_a <= {1'b0, ONE30};
            mul_b <= {1'b0, ONE30};
          end else begin
            mul_a <= {1'b0, q};
            mul_b <= {1'b0, q};
          end
          state <= ST_SIN1;
        end

        ST_SIN1: state <= ST_SIN2;

        ST_SIN2: begin
          q2    <= prod30[30:0];
          mul_a <= SIN_S11;
          mul_b <= prod30;
          k     <= '0;
          state <= ST_SIN3;
        end

        ST_SIN3: state <= ST_SIN4;

        ST_SIN4: begin
          mul_a <= sin_coef(k) - prod30;
          if (k == 3'd4) begin
            mul_b <= {1'b0, q};
            state <= ST_SIN5;
          end else begin
            mul_b <= {1'b0, q2};
            k     <= k + 3'd1;
            state <= ST_SIN3;
          end
        end

        ST_SIN5: state <= ST_SIN6;

        ST_SIN6: begin
          s30 <= sin_r;
          case (seg)
            SEG_C1: begin
              c_r       <= qneg ? $signed(32'd0 - 32'(sin_r)) : $signed(32'(sin_r));
              {qneg, q} <= cos_q({phase[30:0], 1'b0});
              seg       <= SEG_C2;
              state     <= ST_SIN0;
            end
            SEG_C2: begin
              mul_a <= BK_A2;
              mul_b <= qneg ? (32'(ONE30) - 32'(sin_r)) : (32'(ONE30) + 32'(sin_r));
              state <= ST_BKW;
            end
            default: begin
              mul_a <= {1'b0, sin_r};
              mul_b <= {1'b0, sin_r};
              state <= ST_SQW;
            end
          endcase
        end

        ST_SQW: state <= ST_SQ2;

        ST_SQ2: begin
          if (seg == SEG_LEAD) begin
            nl <= to_w(s30);
          end else begin
            nt <= to_w(s30);
          end
          y_neg <= y[31];
          mul_a <= y_mag;
          mul_b <= 32'(to_w(sq_x));
          state <= ST_SCW;
        end

        ST_BKW: state <= ST_BK2;

        ST_BK2: begin
          nl    <= to_w(bk_cl);
          y_neg <= y[31];
          mul_a <= y_mag;
          mul_b <= 32'(to_w(bk_cl));
          state <= ST_SCW;
        end

        ST_SCW: state <= ST_SCL;

        ST_SCL: begin
          y <= sc_y;
          if (seg == SEG_LEAD && trail_r) begin
            div_rem <= '0;
            div_cnt <= DIV_CNT_W'(DIV_W);
            div_quo <= DIV_W'(n_m1 - p_r) << 30;
            div_den <= DIV_W'(t_r);
            seg     <= SEG_TRAIL;
            state   <= ST_DIV;
          end else begin
            state <= ST_ACC;
          end
        end

        ST_ACC: begin
          if (do_acc) begin
            weight_sum   <= weight_sum + 32'(acc_add_l) + 32'(acc_add_t);
            weight_count <= weight_count + CNT_W'(lead_r) + CNT_W'(trail_r);
          end
          if (last_r) begin
            sample_index <= '0;
            if ((norm_r != NORM_OFF)
                && (kind_r == KIND_COSINE || kind_r == KIND_BLACKMAN)) begin
              if (held_norm_seed == '0) begin
                fault_r <= 1'b1;
                nout_r  <= SAT_MAX;
                state   <= ST_OUT;
              end else begin
                fault_r <= 1'b0;
                div_rem <= '0;
                div_cnt <= DIV_CNT_W'(DIV_W);
                div_quo <= TWO48;
                div_den <= DIV_W'(seed_mag);
                seg     <= SEG_NORM1;
                state   <= ST_DIV;
              end
            end else begin
              fault_r <= 1'b0;
              nout_r  <= held_norm_seed;
              state   <= ST_OUT;
            end
          end else begin
            sample_index <= sample_index + IDX_W'(1);
            fault_r      <= 1'b0;
            nout_r       <= '0;
            state        <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {nout_r, 32'(y)};
            m_tlast  <= last_r;
            m_tuser  <= fault_r;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/twt_checker.sv -----
// ---------------------------------------------------------------------------
// twt_checker: port-level checks for the trace window taper
// Watches the streaming ports of the top level over time; bound to it below.
// ---------------------------------------------------------------------------
`default_nettype none

module twt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tuser
);

  // A stalled result holds its data and last flag.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // The sequencer is busy in the cycle after a transaction.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted back to back");

  // Norm fields stay clear except on the last sample.
  a_mid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[63:32] == 32'd0 && !m_tuser)
    else $error("norm output on a middle sample");

  // A fault always comes with the saturated norm.
  a_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[63:32] == 32'h7FFF_FFFF)
    else $error("fault without saturated norm");

endmodule

bind trace_window_taper twt_checker u_twt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire
